// File: hw/rtl/raf_pkg.sv
// raf_pkg: shared types and constants for the registration association fsm
// item structs, mode enum, operation and result codes, register indexes
// no dependencies
package raf_pkg;

	localparam int DELAY_W     = 24;
	localparam int MAC_W       = 48;
	localparam int MSG_ID_W    = 16;
	localparam int HELLO_W     = 32;
	localparam int TTL_W       = 31;
	localparam int CFG_INDEX_W = 2;

	localparam logic [MAC_W-1:0] MAC_ALL = '1;

	// reset values of the configuration registers
	localparam logic [DELAY_W-1:0] BASE_DELAY_RST = 24'd2000;
	localparam logic [DELAY_W-1:0] DELAY_STEP_RST = 24'd1000;
	localparam logic [DELAY_W-1:0] DELAY_MAX_RST  = 24'd60000;

	// configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_BASE_DELAY = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_DELAY_STEP = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_DELAY_MAX  = 2'd2;

	// input operation codes
	localparam logic [2:0] OP_TICK  = 3'd0;
	localparam logic [2:0] OP_HELLO = 3'd1;
	localparam logic [2:0] OP_ASSOC = 3'd2;
	localparam logic [2:0] OP_CTRL  = 3'd3;
	localparam logic [2:0] OP_DATA  = 3'd4;

	// result kinds
	localparam logic [1:0] KIND_REG = 2'd0;
	localparam logic [1:0] KIND_ACK = 2'd1;
	localparam logic [1:0] KIND_ANS = 2'd2;

	typedef enum logic [2:0] {
		MODE_COLD    = 3'd0,
		MODE_UNKNOWN = 3'd1,
		MODE_KNOWN   = 3'd2,
		MODE_RENEW   = 3'd3,
		MODE_RUNNING = 3'd4
	} mode_t;

	typedef struct packed {
		logic [2:0]          operation;
		logic [MAC_W-1:0]    src_mac;
		logic [MSG_ID_W-1:0] msg_id;
		logic [HELLO_W-1:0]  hello_id;
		logic [TTL_W-1:0]    ttl;
	} raf_in_t;

	typedef struct packed {
		logic [1:0]          kind;
		logic [MAC_W-1:0]    dest_mac;
		logic [MSG_ID_W-1:0] out_msg_id;
		logic                last;
	} raf_out_t;

	typedef struct packed {
		logic [DELAY_W-1:0] base_delay;
		logic [DELAY_W-1:0] delay_step;
		logic [DELAY_W-1:0] delay_max;
	} raf_cfg_t;

	// fixed-width association state
	typedef struct packed {
		mode_t               mode;
		logic [DELAY_W-1:0]  backoff;
		logic [HELLO_W-1:0]  last_hello;
		logic [MAC_W-1:0]    master_mac;
		logic [MSG_ID_W-1:0] next_msg_id;
	} raf_ctl_t;

endpackage

// File: hw/rtl/raf_step.sv
// raf_step: one pass of the association state machine for one item
// combinational; next state and up to two result items
// depends on raf_pkg
module raf_step #(
	parameter int TIME_WIDTH = 32
) (
	input  raf_pkg::raf_in_t        ev,
	input  raf_pkg::raf_cfg_t       cfg,
	input  raf_pkg::raf_ctl_t       ctl,
	input  logic [TIME_WIDTH-1:0]   now_cur,
	input  logic [TIME_WIDTH-1:0]   nrt_cur,
	input  logic [TIME_WIDTH-1:0]   ttl_dl_cur,
	input  logic [TIME_WIDTH-1:0]   rnw_dl_cur,
	output raf_pkg::raf_ctl_t       ctl_nx,
	output logic [TIME_WIDTH-1:0]   now_nx,
	output logic [TIME_WIDTH-1:0]   nrt_nx,
	output logic [TIME_WIDTH-1:0]   ttl_dl_nx,
	output logic [TIME_WIDTH-1:0]   rnw_dl_nx,
	output raf_pkg::raf_out_t       r0,
	output raf_pkg::raf_out_t       r1,
	output logic [1:0]              nres
);

	// wrapping time compare: a - b negative
	function automatic logic t_lt(input logic [TIME_WIDTH-1:0] a,
			input logic [TIME_WIDTH-1:0] b);
		logic [TIME_WIDTH-1:0] d;
		d = a - b;
		return d[TIME_WIDTH-1];
	endfunction

	function automatic logic t_le(input logic [TIME_WIDTH-1:0] a,
			input logic [TIME_WIDTH-1:0] b);
		return t_lt(a, b) || (a == b);
	endfunction

	function automatic raf_pkg::raf_out_t mk(input logic [1:0] kind,
			input logic [raf_pkg::MAC_W-1:0] dest, input logic [raf_pkg::MSG_ID_W-1:0] id);
		raf_pkg::raf_out_t r;
		r.kind       = kind;
		r.dest_mac   = dest;
		r.out_msg_id = id;
		r.last       = 1'b0;
		return r;
	endfunction

	logic                            hello;
	logic [TIME_WIDTH-1:0]           now_n;
	logic [TIME_WIDTH-1:0]           nrt;
	logic [TIME_WIDTH-1:0]           tdl;
	logic [TIME_WIDTH-1:0]           rdl;
	raf_pkg::mode_t                  m;
	logic [raf_pkg::DELAY_W-1:0]     bo;
	logic [raf_pkg::DELAY_W:0]       bo_sum;
	logic [raf_pkg::HELLO_W-1:0]     lh;
	logic [raf_pkg::MAC_W-1:0]       mac;
	logic [raf_pkg::MSG_ID_W-1:0]    nmi;
	logic [1:0]                      cn;
	raf_pkg::raf_out_t               cand [3];

	// next state and the list of emitted items, in emission order
	always_comb begin
		hello  = (ev.operation == raf_pkg::OP_HELLO) && (ev.hello_id != ctl.last_hello);
		now_n  = now_cur + TIME_WIDTH'(ev.operation == raf_pkg::OP_TICK);
		nrt    = nrt_cur;
		tdl    = ttl_dl_cur;
		rdl    = rnw_dl_cur;
		m      = ctl.mode;
		bo     = ctl.backoff;
		bo_sum = '0;
		lh     = hello ? ev.hello_id : ctl.last_hello;
		mac    = ctl.master_mac;
		nmi    = ctl.next_msg_id;
		cn     = '0;
		cand[0] = '0;
		cand[1] = '0;
		cand[2] = '0;

		unique case (m) inside
			raf_pkg::MODE_COLD, raf_pkg::MODE_UNKNOWN: begin
				// first item after reset registers at once
				if (m == raf_pkg::MODE_COLD) begin
					cand[cn] = mk(raf_pkg::KIND_REG, mac, nmi);
					cn  = cn + 2'd1;
					nmi = nmi + 16'd1;
					m   = raf_pkg::MODE_UNKNOWN;
					bo  = cfg.base_delay;
					nrt = now_n + TIME_WIDTH'(cfg.base_delay);
				end
				if (hello) begin
					mac = ev.src_mac;
					nmi = ev.msg_id + 16'd1;
					bo  = cfg.base_delay;
					nrt = now_n + TIME_WIDTH'(cfg.base_delay);
					m   = raf_pkg::MODE_KNOWN;
				end else if (ev.operation == raf_pkg::OP_ASSOC) begin
					mac = ev.src_mac;
					nmi = ev.msg_id + 16'd1;
					m   = raf_pkg::MODE_RUNNING;
					cand[cn] = mk(raf_pkg::KIND_ACK, ev.src_mac, ev.msg_id);
					cn  = cn + 2'd1;
					bo  = cfg.base_delay;
					tdl = now_n + TIME_WIDTH'(ev.ttl);
					rdl = now_n + TIME_WIDTH'(ev.ttl >> 1);
				end
				// registration timer, also after an assoc
				if (t_lt(nrt, now_n)) begin
					cand[cn] = mk(raf_pkg::KIND_REG, mac, nmi);
					cn     = cn + 2'd1;
					nmi    = nmi + 16'd1;
					bo_sum = {1'b0, bo} + {1'b0, cfg.delay_step};
					bo     = (bo_sum > {1'b0, cfg.delay_max}) ? cfg.delay_max
						: bo_sum[raf_pkg::DELAY_W-1:0];
					nrt    = now_n + TIME_WIDTH'(bo);
				end
			end
			raf_pkg::MODE_KNOWN: begin
				if (hello) begin
					mac = ev.src_mac;
					nmi = ev.msg_id + 16'd1;
					bo  = cfg.base_delay;
					nrt = now_n + TIME_WIDTH'(cfg.base_delay);
				end else if (ev.operation == raf_pkg::OP_ASSOC) begin
					mac = ev.src_mac;
					nmi = ev.msg_id + 16'd1;
					m   = raf_pkg::MODE_RUNNING;
					cand[cn] = mk(raf_pkg::KIND_ACK, ev.src_mac, ev.msg_id);
					cn  = cn + 2'd1;
					bo  = cfg.base_delay;
					tdl = now_n + TIME_WIDTH'(ev.ttl);
					rdl = now_n + TIME_WIDTH'(ev.ttl >> 1);
				end
				if (m == raf_pkg::MODE_KNOWN) begin
					// backoff at its cap and run out: drop the master
					if (bo == cfg.delay_max && t_le(nrt, now_n)) begin
						mac = raf_pkg::MAC_ALL;
						lh  = '0;
						bo  = cfg.base_delay;
						nrt = now_n + TIME_WIDTH'(cfg.base_delay);
						m   = raf_pkg::MODE_UNKNOWN;
					end
					if (t_lt(nrt, now_n)) begin
						cand[cn] = mk(raf_pkg::KIND_REG, mac, nmi);
						cn     = cn + 2'd1;
						nmi    = nmi + 16'd1;
						bo_sum = {1'b0, bo} + {1'b0, cfg.delay_step};
						bo     = (bo_sum > {1'b0, cfg.delay_max}) ? cfg.delay_max
							: bo_sum[raf_pkg::DELAY_W-1:0];
						nrt    = now_n + TIME_WIDTH'(bo);
					end
				end
			end
			raf_pkg::MODE_RENEW: begin
				if (hello) begin
					mac = ev.src_mac;
					nmi = ev.msg_id + 16'd1;
					bo  = cfg.base_delay;
					nrt = now_n + TIME_WIDTH'(cfg.base_delay);
					m   = raf_pkg::MODE_KNOWN;
					cand[cn] = mk(raf_pkg::KIND_REG, mac, nmi);
					cn  = cn + 2'd1;
					nmi = nmi + 16'd1;
				end else if (ev.operation == raf_pkg::OP_ASSOC) begin
					mac = ev.src_mac;
					nmi = ev.msg_id + 16'd1;
					m   = raf_pkg::MODE_RUNNING;
					cand[cn] = mk(raf_pkg::KIND_ACK, ev.src_mac, ev.msg_id);
					cn  = cn + 2'd1;
					bo  = cfg.base_delay;
					tdl = now_n + TIME_WIDTH'(ev.ttl);
					rdl = now_n + TIME_WIDTH'(ev.ttl >> 1);
				end
				if (m == raf_pkg::MODE_RENEW) begin
					// resend: backoff grows before the item goes out
					if (t_lt(nrt, now_n)) begin
						bo_sum = {1'b0, bo} + {1'b0, cfg.delay_step};
						bo     = (bo_sum > {1'b0, cfg.delay_max}) ? cfg.delay_max
							: bo_sum[raf_pkg::DELAY_W-1:0];
						nrt    = now_n + TIME_WIDTH'(bo);
						cand[cn] = mk(raf_pkg::KIND_REG, mac, nmi);
						cn     = cn + 2'd1;
						nmi    = nmi + 16'd1;
					end
					// lifetime over: forget master, broadcast a registration
					if (t_le(tdl, now_n)) begin
						mac = raf_pkg::MAC_ALL;
						lh  = '0;
						m   = raf_pkg::MODE_UNKNOWN;
						bo  = cfg.base_delay;
						cand[cn] = mk(raf_pkg::KIND_REG, mac, nmi);
						cn  = cn + 2'd1;
						nmi = nmi + 16'd1;
					end
				end
			end
			default: begin
				// running
				if (hello) begin
					mac = ev.src_mac;
					nmi = ev.msg_id + 16'd1;
					bo  = cfg.base_delay;
					nrt = now_n + TIME_WIDTH'(cfg.base_delay);
					m   = raf_pkg::MODE_KNOWN;
				end else if (ev.operation == raf_pkg::OP_ASSOC) begin
					mac = ev.src_mac;
					nmi = ev.msg_id + 16'd1;
					m   = raf_pkg::MODE_RUNNING;
					cand[cn] = mk(raf_pkg::KIND_ACK, ev.src_mac, ev.msg_id);
					cn  = cn + 2'd1;
					bo  = cfg.base_delay;
					tdl = now_n + TIME_WIDTH'(ev.ttl);
					rdl = now_n + TIME_WIDTH'(ev.ttl >> 1);
				end else if (ev.operation == raf_pkg::OP_DATA) begin
					cand[cn] = mk(raf_pkg::KIND_ANS, mac, ev.msg_id);
					cn = cn + 2'd1;
				end
				// half lifetime gone: start renewing
				if (m == raf_pkg::MODE_RUNNING && t_le(rdl, now_n)) begin
					cand[cn] = mk(raf_pkg::KIND_REG, mac, nmi);
					cn  = cn + 2'd1;
					nmi = nmi + 16'd1;
					bo  = cfg.base_delay;
					nrt = now_n + TIME_WIDTH'(cfg.base_delay);
					m   = raf_pkg::MODE_RENEW;
				end
			end
		endcase

		ctl_nx.mode        = m;
		ctl_nx.backoff     = bo;
		ctl_nx.last_hello  = lh;
		ctl_nx.master_mac  = mac;
		ctl_nx.next_msg_id = nmi;
		now_nx    = now_n;
		nrt_nx    = nrt;
		ttl_dl_nx = tdl;
		rnw_dl_nx = rdl;
	end

	// output items: at most two, the final one marked
	always_comb begin
		nres = (cn > 2'd2) ? 2'd2 : cn;
		r0 = cand[0];
		r1 = cand[1];
		r0.last = (nres == 2'd1);
		r1.last = (nres == 2'd2);
	end

endmodule

// File: hw/rtl/raf_resq.sv
// raf_resq: two-entry result queue between the step logic and the output channel
// takes up to two items at once, hands out one per cycle while stall is low
// depends on raf_pkg
module raf_resq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [1:0]        nres,
	input  raf_pkg::raf_out_t r0,
	input  raf_pkg::raf_out_t r1,
	input  logic              stall,
	output logic              room,
	output logic              valid,
	output raf_pkg::raf_out_t head
);

	logic [1:0]        cnt_q;
	raf_pkg::raf_out_t q0_q;
	raf_pkg::raf_out_t q1_q;
	logic              pop;

	// handshake and free space
	assign valid = (cnt_q != 2'd0);
	assign head  = q0_q;
	assign pop   = valid && !stall;
	assign room  = (cnt_q == 2'd0) || (cnt_q == 2'd1 && pop);

	// fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (push) begin
			cnt_q <= nres;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	// entries
	always_ff @(posedge clk) begin
		if (push) begin
			q0_q <= r0;
			q1_q <= r1;
		end else if (pop) begin
			q0_q <= q1_q;
		end
	end

endmodule

// File: hw/rtl/registration_association_fsm.sv
// registration_association_fsm: slave-side association state machine, top level
// an item's results are registered in the queue as it leaves the input register
// throughput: one item per cycle with up to one result, while res_stall is low;
//   with two results, the next item waits until the two-entry result queue has room
// reset: async active low; coldstart mode, cfg registers at defaults, queues empty
// depends on raf_pkg, raf_step, raf_resq
module registration_association_fsm #(
	parameter int TIME_WIDTH = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [raf_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [raf_pkg::DELAY_W-1:0]         cfg_data,
	input  logic                                evt_valid,
	output logic                                evt_stall,
	input  raf_pkg::raf_in_t                    evt,
	output logic                                res_valid,
	input  logic                                res_stall,
	output raf_pkg::raf_out_t                   res
);

	raf_pkg::raf_cfg_t       cfg_q;
	raf_pkg::raf_ctl_t       ctl_q;
	raf_pkg::raf_ctl_t       ctl_nx;
	logic [TIME_WIDTH-1:0]   now_q;
	logic [TIME_WIDTH-1:0]   nrt_q;
	logic [TIME_WIDTH-1:0]   ttl_dl_q;
	logic [TIME_WIDTH-1:0]   rnw_dl_q;
	logic [TIME_WIDTH-1:0]   now_nx;
	logic [TIME_WIDTH-1:0]   nrt_nx;
	logic [TIME_WIDTH-1:0]   ttl_dl_nx;
	logic [TIME_WIDTH-1:0]   rnw_dl_nx;
	raf_pkg::raf_in_t        ev_s1;
	logic                    ev_v_s1;
	raf_pkg::raf_out_t       r0;
	raf_pkg::raf_out_t       r1;
	logic [1:0]              nres;
	logic                    room;
	logic                    dispatch;
	logic                    accept;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base_delay <= raf_pkg::BASE_DELAY_RST;
			cfg_q.delay_step <= raf_pkg::DELAY_STEP_RST;
			cfg_q.delay_max  <= raf_pkg::DELAY_MAX_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				raf_pkg::REG_BASE_DELAY: cfg_q.base_delay <= cfg_data;
				raf_pkg::REG_DELAY_STEP: cfg_q.delay_step <= cfg_data;
				raf_pkg::REG_DELAY_MAX:  cfg_q.delay_max  <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register handshake
	assign dispatch  = ev_v_s1 && room;
	assign evt_stall = ev_v_s1 && !dispatch;
	assign accept    = evt_valid && !evt_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_v_s1 <= 1'b0;
		end else if (accept) begin
			ev_v_s1 <= 1'b1;
		end else if (dispatch) begin
			ev_v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ev_s1 <= evt;
		end
	end

	// one pass of the state machine
	raf_step #(
		.TIME_WIDTH(TIME_WIDTH)
	) u_step (
		.ev        (ev_s1),
		.cfg       (cfg_q),
		.ctl       (ctl_q),
		.now_cur   (now_q),
		.nrt_cur   (nrt_q),
		.ttl_dl_cur(ttl_dl_q),
		.rnw_dl_cur(rnw_dl_q),
		.ctl_nx    (ctl_nx),
		.now_nx    (now_nx),
		.nrt_nx    (nrt_nx),
		.ttl_dl_nx (ttl_dl_nx),
		.rnw_dl_nx (rnw_dl_nx),
		.r0        (r0),
		.r1        (r1),
		.nres      (nres)
	);

	// association state, updated when an item leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q.mode        <= raf_pkg::MODE_COLD;
			ctl_q.backoff     <= raf_pkg::BASE_DELAY_RST;
			ctl_q.last_hello  <= '0;
			ctl_q.master_mac  <= raf_pkg::MAC_ALL;
			ctl_q.next_msg_id <= 16'd1;
			now_q             <= '0;
			nrt_q             <= '0;
		end else if (dispatch) begin
			ctl_q <= ctl_nx;
			now_q <= now_nx;
			nrt_q <= nrt_nx;
		end
	end

	// deadlines are written by an assoc before any use
	always_ff @(posedge clk) begin
		if (dispatch) begin
			ttl_dl_q <= ttl_dl_nx;
			rnw_dl_q <= rnw_dl_nx;
		end
	end

	// result queue
	raf_resq u_resq (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (dispatch),
		.nres  (nres),
		.r0    (r0),
		.r1    (r1),
		.stall (res_stall),
		.room  (room),
		.valid (res_valid),
		.head  (res)
	);

endmodule

// File: hw/rtl/raf_checker.sv
// raf_checker: port-level assertions for registration_association_fsm
// attached to the top level by the bind at the end of this file
// depends on raf_pkg
module raf_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            cfg_we,
	input logic [raf_pkg::CFG_INDEX_W-1:0] cfg_index,
	input logic [raf_pkg::DELAY_W-1:0]     cfg_data,
	input logic                            evt_valid,
	input logic                            evt_stall,
	input raf_pkg::raf_in_t                evt,
	input logic                            res_valid,
	input logic                            res_stall,
	input raf_pkg::raf_out_t               res
);

	// a stalled result item holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("result item changed while stalled");

	// only three result kinds exist
	a_res_kind: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res.kind == raf_pkg::KIND_REG || res.kind == raf_pkg::KIND_ACK
			|| res.kind == raf_pkg::KIND_ANS)
		else $error("result item with unknown kind");

	// a taken item that is not the final one is followed at once by the next
	a_res_follow: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_stall && !res.last |=> res_valid)
		else $error("second result item missing");

	// nothing on the output right after reset
	a_res_reset: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !res_valid)
		else $error("result item right after reset");

endmodule

bind registration_association_fsm raf_checker u_raf_checker (.*);

// File: bench/registration_association_fsm_tb.sv
// registration_association_fsm_tb: self-checking bench for the slave association fsm
// an opening table of items, then random event traffic under several delay settings,
// every result checked against typed rows or an in-bench model; depends on raf_pkg
module registration_association_fsm_tb;

	import raf_pkg::*;

	localparam int TIME_W          = 32;
	localparam int PHASES          = 7;
	localparam int ITEMS_PER_PHASE = 243;
	localparam int SETTLE_CYCLES   = 8;
	localparam int RUN_CYCLE_LIMIT = 600000;
	localparam int MAX_REPORTS     = 40;
	localparam int OPENING_LEN     = 21;

	// operation codes the block passes over without a message
	localparam logic [2:0] OP_UNUSED_LO  = 3'd5;
	localparam logic [2:0] OP_UNUSED_MID = 3'd6;
	localparam logic [2:0] OP_UNUSED_HI  = 3'd7;

	localparam raf_out_t NO_MSG = '0;

	typedef struct {
		raf_in_t  ev;
		bit       typed;
		int       n;
		raf_out_t r0;
		raf_out_t r1;
	} opening_row_t;

	// dut signals
	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   cfg_we    = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [DELAY_W-1:0]     cfg_data  = '0;
	logic                   evt_valid = 1'b0;
	logic                   evt_stall;
	raf_in_t                evt       = '0;
	logic                   res_valid;
	logic                   res_stall = 1'b0;
	raf_out_t               res;

	// model state and configuration
	logic [DELAY_W-1:0]  cfg_base;
	logic [DELAY_W-1:0]  cfg_step;
	logic [DELAY_W-1:0]  cfg_max;
	mode_t               st_mode;
	logic [TIME_W-1:0]   st_now;
	logic [TIME_W-1:0]   st_next_reg;
	logic [TIME_W-1:0]   st_backoff;
	logic [TIME_W-1:0]   st_ttl_dl;
	logic [TIME_W-1:0]   st_renew_dl;
	logic [HELLO_W-1:0]  st_last_hello;
	logic [MAC_W-1:0]    st_master;
	logic [MSG_ID_W-1:0] st_next_id;

	raf_out_t    react_out [2];
	int unsigned react_n;
	raf_out_t    owed_msgs [$];
	int unsigned fail_count = 0;
	int unsigned cycle_count = 0;
	int unsigned burst_left = 0;
	int unsigned stall_span = 0;
	int unsigned stall_pct = 0;

	// delay settings per phase: base, step, max
	logic [DELAY_W-1:0] phase_delays [PHASES][3] = '{
		'{24'd1, 24'd0, 24'd1},
		'{24'd3, 24'd2, 24'd12},
		'{24'd1, 24'd1, 24'd6},
		'{24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF},
		'{24'd5, 24'hFFFFFF, 24'd8},
		'{24'd2, 24'd1, 24'hFFFFFF},
		'{24'd10, 24'd3, 24'd4}
	};

	// opening items under reset delays; typed rows carry their results
	opening_row_t opening_items [OPENING_LEN] = '{
		'{'{OP_ASSOC, 48'h0000_0000_0001, 16'h0000, 32'h0, 31'd4}, 1'b1, 2,
			'{KIND_REG, MAC_ALL, 16'd1, 1'b0}, '{KIND_ACK, 48'h0000_0000_0001, 16'h0000, 1'b1}},
		'{'{OP_HELLO, 48'hFFFF_FFFF_FFFF, 16'h5A5A, 32'h0, 31'd0}, 1'b1, 0, NO_MSG, NO_MSG},
		'{'{OP_UNUSED_LO, 48'h0, 16'h0, 32'h0, 31'd0}, 1'b1, 0, NO_MSG, NO_MSG},
		'{'{OP_UNUSED_HI, 48'hFFFF_FFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF}, 1'b1, 0,
			NO_MSG, NO_MSG},
		'{'{OP_CTRL, 48'h0, 16'h0, 32'h0, 31'd0}, 1'b1, 0, NO_MSG, NO_MSG},
		'{'{OP_DATA, 48'h1234_5678_9ABC, 16'hFFFF, 32'h0, 31'd0}, 1'b1, 1,
			'{KIND_ANS, 48'h0000_0000_0001, 16'hFFFF, 1'b1}, NO_MSG},
		'{'{OP_TICK, 48'h0, 16'h0, 32'h0, 31'd0}, 1'b1, 0, NO_MSG, NO_MSG},
		'{'{OP_TICK, 48'h0, 16'h0, 32'h0, 31'd0}, 1'b1, 1,
			'{KIND_REG, 48'h0000_0000_0001, 16'd1, 1'b1}, NO_MSG},
		'{'{OP_DATA, 48'h0, 16'h1234, 32'h0, 31'd0}, 1'b0, 0, NO_MSG, NO_MSG},
		'{'{OP_TICK, 48'h0, 16'h0, 32'h0, 31'd0}, 1'b0, 0, NO_MSG, NO_MSG},
		'{'{OP_TICK, 48'h0, 16'h0, 32'h0, 31'd0}, 1'b1, 1,
			'{KIND_REG, MAC_ALL, 16'd2, 1'b1}, NO_MSG},
		'{'{OP_HELLO, 48'h8000_0000_0000, 16'hFFFF, 32'hFFFF_FFFF, 31'd0}, 1'b1, 0,
			NO_MSG, NO_MSG},
		'{'{OP_HELLO, 48'h0000_0000_0002, 16'h0001, 32'hFFFF_FFFF, 31'd0}, 1'b0, 0,
			NO_MSG, NO_MSG},
		'{'{OP_ASSOC, 48'h7FFF_FFFF_FFFF, 16'h8000, 32'h0, 31'h7FFF_FFFF}, 1'b1, 1,
			'{KIND_ACK, 48'h7FFF_FFFF_FFFF, 16'h8000, 1'b1}, NO_MSG},
		'{'{OP_DATA, 48'h0, 16'h0000, 32'h0, 31'd0}, 1'b1, 1,
			'{KIND_ANS, 48'h7FFF_FFFF_FFFF, 16'h0000, 1'b1}, NO_MSG},
		'{'{OP_HELLO, 48'hA5A5_5A5A_F00F, 16'h1234, 32'h0, 31'd0}, 1'b0, 0, NO_MSG, NO_MSG},
		'{'{OP_UNUSED_MID, 48'h0, 16'h0, 32'h0, 31'd0}, 1'b0, 0, NO_MSG, NO_MSG},
		'{'{OP_ASSOC, 48'h0, 16'h4321, 32'h0, 31'd1}, 1'b0, 0, NO_MSG, NO_MSG},
		'{'{OP_DATA, 48'h0, 16'h5555, 32'h0, 31'd0}, 1'b0, 0, NO_MSG, NO_MSG},
		'{'{OP_TICK, 48'h0, 16'h0, 32'h0, 31'd0}, 1'b0, 0, NO_MSG, NO_MSG},
		'{'{OP_TICK, 48'h0, 16'h0, 32'h0, 31'd0}, 1'b0, 0, NO_MSG, NO_MSG}
	};

	registration_association_fsm #(.TIME_WIDTH(TIME_W)) u_top (
		.clk,
		.arst_n,
		.cfg_we,
		.cfg_index,
		.cfg_data,
		.evt_valid,
		.evt_stall,
		.evt,
		.res_valid,
		.res_stall,
		.res
	);

	// wrapping time compares relative to the current time
	function automatic bit earlier(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
		logic [TIME_W-1:0] d;
		d = a - b;
		return d[TIME_W-1];
	endfunction

	function automatic bit reached(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
		logic [TIME_W-1:0] d;
		d = a - b;
		return d[TIME_W-1] || d == '0;
	endfunction

	// at most two messages per item, later ones dropped
	function automatic void emit_msg(logic [1:0] kind, logic [MAC_W-1:0] dest,
	                                 logic [MSG_ID_W-1:0] id);
		if (react_n < 2) begin
			react_out[react_n].kind       = kind;
			react_out[react_n].dest_mac   = dest;
			react_out[react_n].out_msg_id = id;
			react_out[react_n].last       = 1'b0;
			react_n++;
		end
	endfunction

	function automatic void send_reg();
		emit_msg(KIND_REG, st_master, st_next_id);
		st_next_id = st_next_id + 1'b1;
	endfunction

	function automatic void restart_backoff();
		st_backoff  = TIME_W'(cfg_base);
		st_next_reg = st_now + st_backoff;
	endfunction

	function automatic void grow_backoff();
		longint unsigned n;
		n = 64'(st_backoff) + 64'(cfg_step);
		st_backoff  = (n > 64'(cfg_max)) ? TIME_W'(cfg_max) : TIME_W'(n);
		st_next_reg = st_now + st_backoff;
	endfunction

	function automatic void take_hello(raf_in_t ev);
		st_master  = ev.src_mac;
		st_next_id = ev.msg_id + 1'b1;
		restart_backoff();
	endfunction

	function automatic void ack_assoc(raf_in_t ev);
		st_master  = ev.src_mac;
		st_next_id = ev.msg_id + 1'b1;
		st_mode    = MODE_RUNNING;
		emit_msg(KIND_ACK, st_master, ev.msg_id);
		st_backoff  = TIME_W'(cfg_base);
		st_ttl_dl   = st_now + TIME_W'(ev.ttl);
		st_renew_dl = st_now + TIME_W'(ev.ttl >> 1);
	endfunction

	function automatic void forget_master();
		st_master     = MAC_ALL;
		st_last_hello = '0;
	endfunction

	// one pass of the fsm for one item; returns the number of messages it sends
	function automatic int unsigned assoc_react(raf_in_t ev);
		bit fresh;
		fresh   = 1'b0;
		react_n = 0;
		if (ev.operation == OP_TICK)
			st_now = st_now + 1'b1;
		if (ev.operation == OP_HELLO && st_mode != MODE_COLD && ev.hello_id != st_last_hello) begin
			st_last_hello = ev.hello_id;
			fresh = 1'b1;
		end
		case (st_mode)
			MODE_COLD, MODE_UNKNOWN: begin
				// coldstart registers once, then behaves as waiting unknown
				if (st_mode == MODE_COLD) begin
					send_reg();
					st_mode = MODE_UNKNOWN;
					restart_backoff();
					if (ev.operation == OP_HELLO && ev.hello_id != st_last_hello) begin
						st_last_hello = ev.hello_id;
						fresh = 1'b1;
					end
				end
				if (fresh) begin
					take_hello(ev);
					st_mode = MODE_KNOWN;
				end else if (ev.operation == OP_ASSOC) begin
					ack_assoc(ev);
				end
				if (earlier(st_next_reg, st_now)) begin
					send_reg();
					grow_backoff();
				end
			end
			MODE_KNOWN: begin
				if (fresh)
					take_hello(ev);
				else if (ev.operation == OP_ASSOC)
					ack_assoc(ev);
				if (st_mode == MODE_KNOWN) begin
					// backoff at its cap and run out: drop the master
					if (st_backoff == TIME_W'(cfg_max) && reached(st_next_reg, st_now)) begin
						forget_master();
						restart_backoff();
						st_mode = MODE_UNKNOWN;
					end
					if (earlier(st_next_reg, st_now)) begin
						send_reg();
						grow_backoff();
					end
				end
			end
			MODE_RENEW: begin
				if (fresh) begin
					take_hello(ev);
					st_mode = MODE_KNOWN;
					send_reg();
				end else if (ev.operation == OP_ASSOC) begin
					ack_assoc(ev);
				end
				if (st_mode == MODE_RENEW) begin
					if (earlier(st_next_reg, st_now)) begin
						grow_backoff();
						send_reg();
					end
					// lifetime over: broadcast registration, timer untouched
					if (reached(st_ttl_dl, st_now)) begin
						forget_master();
						st_mode    = MODE_UNKNOWN;
						st_backoff = TIME_W'(cfg_base);
						send_reg();
					end
				end
			end
			default: begin
				if (fresh) begin
					take_hello(ev);
					st_mode = MODE_KNOWN;
				end else if (ev.operation == OP_ASSOC) begin
					ack_assoc(ev);
				end else if (ev.operation == OP_DATA) begin
					emit_msg(KIND_ANS, st_master, ev.msg_id);
				end
				if (st_mode == MODE_RUNNING && reached(st_renew_dl, st_now)) begin
					send_reg();
					restart_backoff();
					st_mode = MODE_RENEW;
				end
			end
		endcase
		if (react_n > 0)
			react_out[react_n-1].last = 1'b1;
		return react_n;
	endfunction

	// random event, weighted toward ticks; few hellos once associated
	function automatic raf_in_t random_event();
		raf_in_t     ev;
		logic [63:0] w;
		int unsigned pick;
		int unsigned hello_w;
		w = {$urandom, $urandom};
		case ($urandom_range(7))
			0: ev.src_mac = MAC_ALL;
			1: ev.src_mac = '0;
			default: ev.src_mac = w[MAC_W-1:0];
		endcase
		ev.msg_id   = MSG_ID_W'($urandom);
		ev.hello_id = $urandom;
		if ($urandom_range(9) == 0)
			ev.ttl = TTL_W'($urandom);
		else
			ev.ttl = TTL_W'($urandom_range(0, 40));
		hello_w = (st_mode == MODE_RUNNING || st_mode == MODE_RENEW) ? 4 : 15;
		pick = $urandom_range(99);
		if (pick < 50) begin
			ev.operation = OP_TICK;
		end else if (pick < 50 + hello_w) begin
			ev.operation = OP_HELLO;
			if ($urandom_range(3) == 0)
				ev.hello_id = st_last_hello;
		end else if (pick < 58 + hello_w) begin
			ev.operation = OP_ASSOC;
		end else if (pick < 63 + hello_w) begin
			ev.operation = OP_CTRL;
		end else if (pick < 67 + hello_w) begin
			ev.operation = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
		end else begin
			ev.operation = OP_DATA;
		end
		return ev;
	endfunction

	// sender pacing: bursts of random length, random gaps between them
	function automatic int unsigned pace_gap();
		if (burst_left > 1) begin
			burst_left--;
			return 0;
		end
		burst_left = $urandom_range(1, 24);
		if ($urandom_range(3) == 0)
			return 0;
		return $urandom_range(1, 5);
	endfunction

	// offer one item, record its messages once taken
	task automatic deliver(input raf_in_t ev, input bit typed, input int n_typed,
	                       input raf_out_t t0, input raf_out_t t1);
		int unsigned n;
		int unsigned gap;
		evt       <= ev;
		evt_valid <= 1'b1;
		@(posedge clk);
		while (evt_stall)
			@(posedge clk);
		n = assoc_react(ev);
		if (typed) begin
			if (n_typed > 0)
				owed_msgs.push_back(t0);
			if (n_typed > 1)
				owed_msgs.push_back(t1);
		end else begin
			for (int i = 0; i < n; i++)
				owed_msgs.push_back(react_out[i]);
		end
		gap = pace_gap();
		if (gap != 0) begin
			evt_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// stop sending and let every owed message come back
	task automatic drain();
		evt_valid <= 1'b0;
		while (owed_msgs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic program_delays(input logic [DELAY_W-1:0] base, input logic [DELAY_W-1:0] step,
	                              input logic [DELAY_W-1:0] cap);
		cfg_we    <= 1'b1;
		cfg_index <= REG_BASE_DELAY;
		cfg_data  <= base;
		@(posedge clk);
		cfg_index <= REG_DELAY_STEP;
		cfg_data  <= step;
		@(posedge clk);
		cfg_index <= REG_DELAY_MAX;
		cfg_data  <= cap;
		@(posedge clk);
		cfg_we   <= 1'b0;
		cfg_base = base;
		cfg_step = step;
		cfg_max  = cap;
	endtask

	// clock
	initial begin
		forever #2 clk = ~clk;
	end

	// receiver stall pattern: windows of random length, each with its own stall rate
	always @(posedge clk) begin
		if (stall_span == 0) begin
			stall_span = $urandom_range(32, 256);
			case ($urandom_range(4))
				0, 1: stall_pct = 0;
				2: stall_pct = 30;
				3: stall_pct = 60;
				default: stall_pct = 90;
			endcase
		end
		stall_span--;
		res_stall <= ($urandom_range(99) < stall_pct);
	end

	// result checker
	always @(posedge clk) begin
		raf_out_t want;
		if (arst_n && res_valid === 1'b1 && res_stall === 1'b0) begin
			if (owed_msgs.size() == 0) begin
				fail_count++;
				if (fail_count <= MAX_REPORTS)
					$display("%0t: unexpected result kind %0d dest %h id %h last %b",
						$time, res.kind, res.dest_mac, res.out_msg_id, res.last);
			end else begin
				want = owed_msgs.pop_front();
				if (res.kind !== want.kind || res.dest_mac !== want.dest_mac
				    || res.out_msg_id !== want.out_msg_id || res.last !== want.last) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS)
						$display("%0t: expected kind %0d dest %h id %h last %b, got kind %0d dest %h id %h last %b",
							$time, want.kind, want.dest_mac, want.out_msg_id, want.last,
							res.kind, res.dest_mac, res.out_msg_id, res.last);
				end
			end
		end
	end

	// run limit
	initial begin
		while (cycle_count < RUN_CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAILURE");
		$finish;
	end

	// stimulus
	initial begin
		int unsigned counted;
		raf_in_t     ev;
		cfg_base      = BASE_DELAY_RST;
		cfg_step      = DELAY_STEP_RST;
		cfg_max       = DELAY_MAX_RST;
		st_mode       = MODE_COLD;
		st_now        = '0;
		st_next_reg   = '0;
		st_backoff    = TIME_W'(BASE_DELAY_RST);
		st_ttl_dl     = '0;
		st_renew_dl   = '0;
		st_last_hello = '0;
		st_master     = MAC_ALL;
		st_next_id    = 16'd1;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (opening_items[i])
			deliver(opening_items[i].ev, opening_items[i].typed, opening_items[i].n,
				opening_items[i].r0, opening_items[i].r1);

		for (int p = 0; p < PHASES; p++) begin
			drain();
			program_delays(phase_delays[p][0], phase_delays[p][1], phase_delays[p][2]);
			counted = 0;
			while (counted < ITEMS_PER_PHASE) begin
				ev = random_event();
				counted++;
				deliver(ev, 1'b0, 0, NO_MSG, NO_MSG);
			end
		end

		drain();
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
